// ===== sv/ais_pkg.sv =====
// ais_pkg: shared types, codes and constants of the annealing independent set step
// used by the channel interfaces, the divider, the multiplier and the top level
package ais_pkg;

    localparam int MAX_NODES = 32;
    localparam int NODE_LIM  = (MAX_NODES < 32) ? MAX_NODES : 32;
    localparam int SET_W     = 32;
    localparam int COST_W    = 12;
    localparam int TEMP_W    = 32;
    localparam int DIV_W     = 35;
    localparam int EXP_BITS  = 13;
    localparam logic [12:0] X_MAX  = 13'd4096;
    localparam logic [16:0] RATE_ONE = 17'd65536;
    localparam logic [63:0] Q62_ONE  = 64'h4000_0000_0000_0000;

    localparam logic [5:0]  NODE_COUNT_RST = 6'd32;
    localparam logic [31:0] INIT_TEMP_RST  = 32'd65536;
    localparam logic [16:0] COOL_RATE_RST  = 17'd64880;

    typedef enum logic [1:0] {
        ACT_LOAD_ROW = 2'd0,
        ACT_LOAD_SET = 2'd1,
        ACT_PROPOSE  = 2'd2,
        ACT_FINISH   = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        ST_DEPENDENT = 3'd0,
        ST_ACCEPTED  = 3'd1,
        ST_REJECTED  = 3'd2,
        ST_LOADED    = 3'd3,
        ST_FINISHED  = 3'd4
    } t_status;

    localparam logic [1:0] REG_NODE_COUNT = 2'd0;
    localparam logic [1:0] REG_INIT_TEMP  = 2'd1;
    localparam logic [1:0] REG_COOL_RATE  = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_EVAL,
        S_DIV,
        S_EXP_CHK,
        S_MUL,
        S_ACC,
        S_COOL,
        S_COOL_ACC,
        S_RESULT
    } t_state;

    typedef logic [63:0] t_pow_tab [EXP_BITS];

    // truncated series terms of e^(-1/256) in q2.62; the seventh term is zero
    localparam logic [63:0] EXP_T1 = Q62_ONE / 64'd256;
    localparam logic [63:0] EXP_T2 = EXP_T1 / 64'd512;
    localparam logic [63:0] EXP_T3 = EXP_T2 / 64'd768;
    localparam logic [63:0] EXP_T4 = EXP_T3 / 64'd1024;
    localparam logic [63:0] EXP_T5 = EXP_T4 / 64'd1280;
    localparam logic [63:0] EXP_T6 = EXP_T5 / 64'd1536;
    localparam logic [63:0] EXP_BASE = Q62_ONE - EXP_T1 + EXP_T2 - EXP_T3 + EXP_T4
                                       - EXP_T5 + EXP_T6;

    // truncated q2.62 product
    function automatic logic [63:0] ais_mul_q62(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[125:62];
    endfunction

    // e^(-1/256) and its squarings e^(-2^k/256)
    function automatic t_pow_tab ais_pow_table();
        logic [63:0] base;
        t_pow_tab    tab;
        base = EXP_BASE;
        for (int i = 0; i < EXP_BITS; i++) begin
            tab[i] = base;
            base   = ais_mul_q62(base, base);
        end
        return tab;
    endfunction

    localparam t_pow_tab POW_TAB = ais_pow_table();

endpackage

// ===== sv/ais_if.sv =====
// ais_if: valid/ready channels of the block: input items, results, register writes
// depends on ais_pkg for field widths
interface ais_in_if;
    import ais_pkg::*;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [4:0]  row_index;
    logic [31:0] vertex_bits;
    logic [15:0] random_fraction;
    logic [4:0]  random_index;
    modport source (output valid, action, row_index, vertex_bits, random_fraction,
                    random_index, input ready);
    modport sink   (input valid, action, row_index, vertex_bits, random_fraction,
                    random_index, output ready);
endinterface

interface ais_out_if;
    import ais_pkg::*;
    logic               valid;
    logic               ready;
    logic [2:0]         status;
    logic [SET_W-1:0]   held_set;
    logic signed [11:0] set_cost;
    logic [TEMP_W-1:0]  temperature_now;
    modport source (output valid, status, held_set, set_cost, temperature_now, input ready);
    modport sink   (input valid, status, held_set, set_cost, temperature_now, output ready);
endinterface

interface ais_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/ais_div.sv =====
// ais_div: restoring divider, one quotient bit per cycle
// depends on ais_pkg for the dividend width
module ais_div
    import ais_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DIV_W-1:0] i_dividend,
    input  logic [31:0]      i_divisor,
    output logic             o_done,
    output logic [DIV_W-1:0] o_quot,
    output logic [31:0]      o_rem
);
    logic [DIV_W-1:0] r_quo;
    logic [32:0]      r_rem;
    logic [31:0]      r_dvs;
    logic [5:0]       r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [32:0]      trial;
    logic             fits;

    assign trial = {r_rem[31:0], r_quo[DIV_W-1]};
    assign fits  = trial >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'(DIV_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= fits ? (trial - {1'b0, r_dvs}) : trial;
            r_quo <= {r_quo[DIV_W-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;
    assign o_rem  = r_rem[31:0];
endmodule

// ===== sv/ais_mul.sv =====
// ais_mul: shared 32x32 multiplier with registered product
// used for the q2.62 exponent products and for cooling
module ais_mul
    import ais_pkg::*;
(
    input  logic        i_clk,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [63:0] o_p
);
    logic [63:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= {32'd0, i_a} * {32'd0, i_b};
    end

    assign o_p = r_p;
endmodule

// ===== sv/annealing_independent_set_step.sv =====
// Simulated annealing step for a maximum independent set, qubo cost.
// Channels: i_in takes one item (action, row_index, vertex_bits, random_fraction,
// random_index); o_out gives exactly one result per item (status, held_set,
// set_cost, temperature_now); i_cfg writes node_count (0), initial_temperature (1),
// cooling_rate (2), always ready; the user must write them only while the block is
// idle, which the block does not enforce. One item at a time: i_in.ready is high
// only in the idle state. From input transfer to result: load row goes straight
// to the result; load set runs the 32-row adjacency scan, one row per cycle;
// finish goes to the result, or with an empty set first runs the divider to give
// random_index mod n; propose scans, evaluates and goes to the result when
// dependent, to cooling when cheaper or at zero temperature, otherwise divides,
// makes 14 exponent bit checks with up to 12 products on the shared 32x32
// multiplier, then cools and goes to the output.
// The result sits in an output register; while a stalled receiver leaves an earlier
// result in it, the block waits in its result state, then goes idle for a new item.
// Reset (synchronous, active low) clears the adjacency rows, set, cost, and loads
// the register reset values and temperature 65536.
module annealing_independent_set_step
    import ais_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    ais_in_if.sink    i_in,
    ais_out_if.source o_out,
    ais_cfg_if.sink   i_cfg
);
    t_state r_state, n_state;

    logic [SET_W-1:0]       r_rows [MAX_NODES];
    logic [5:0]             r_node_count;
    logic [31:0]            r_init_temp;
    logic [16:0]            r_cool_rate;
    logic [SET_W-1:0]       r_cur_set;
    logic signed [11:0]     r_cur_cost;
    logic [TEMP_W-1:0]      r_temp;

    t_action                r_act;
    logic [SET_W-1:0]       r_cand;
    logic [15:0]            r_rnd;
    logic [4:0]             r_idx;
    logic signed [11:0]     r_cost;
    logic                   r_dep;
    logic                   r_take;
    logic [EXP_BITS-1:0]    r_x;
    logic [3:0]             r_k;
    logic [1:0]             r_ph;
    logic [63:0]            r_res;
    logic [127:0]           r_acc;
    t_status                r_status;

    logic                   r_out_valid;
    t_status                r_out_status;
    logic [SET_W-1:0]       r_out_set;
    logic signed [11:0]     r_out_cost;
    logic [TEMP_W-1:0]      r_out_temp;

    logic [5:0]             eff_n;
    logic [SET_W-1:0]       node_mask;
    logic                   in_xfer;
    logic                   out_free;
    logic [SET_W-1:0]       row_now;
    logic [SET_W-1:0]       bit_now;
    logic [5:0]             pc;
    logic signed [12:0]     delta;
    logic                   div_start;
    logic [DIV_W-1:0]       div_dividend;
    logic [31:0]            div_divisor;
    logic                   div_done;
    logic [DIV_W-1:0]       div_quot;
    logic [31:0]            div_rem;
    logic [31:0]            mul_a;
    logic [31:0]            mul_b;
    logic [63:0]            mul_p;
    logic [63:0]            pow_now;
    logic [127:0]           acc_add;
    logic [127:0]           acc_new;
    logic [16:0]            rate_sat;

    always_comb begin
        if (r_node_count == 6'd0)              eff_n = 6'd1;
        else if (r_node_count > 6'(NODE_LIM))  eff_n = 6'(NODE_LIM);
        else                                   eff_n = r_node_count;
    end
    assign node_mask = ~({SET_W{1'b1}} << eff_n);

    assign in_xfer  = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_out.ready;
    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;

    assign row_now = r_rows[r_idx] & node_mask;
    assign bit_now = {{(SET_W-1){1'b0}}, 1'b1} << r_idx;
    assign pc      = 6'($countones(row_now & r_cand & ~bit_now));
    assign delta   = 13'(r_cost) - 13'(r_cur_cost);
    assign rate_sat = (r_cool_rate > RATE_ONE) ? RATE_ONE : r_cool_rate;
    assign pow_now  = POW_TAB[r_k];

    // divider requests: mod for finish with an empty set, delta*2^24/T for propose
    always_comb begin
        div_start    = 1'b0;
        div_dividend = {{(DIV_W-5){1'b0}}, i_in.random_index};
        div_divisor  = {26'd0, eff_n};
        if (r_state == S_IDLE && in_xfer && t_action'(i_in.action) == ACT_FINISH &&
            r_cur_set == '0) begin
            div_start = 1'b1;
        end else if (r_state == S_EVAL && !delta[12] && r_temp != '0) begin
            div_start    = 1'b1;
            div_dividend = {delta[10:0], 24'd0};
            div_divisor  = r_temp;
        end
    end

    ais_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    always_comb begin
        if (r_state == S_COOL) begin
            mul_a = r_temp;
            mul_b = {15'd0, rate_sat};
        end else begin
            mul_a = r_ph[1] ? r_res[63:32] : r_res[31:0];
            mul_b = r_ph[0] ? pow_now[63:32] : pow_now[31:0];
        end
    end

    ais_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    // partial products: lo*lo, lo*hi, hi*lo, hi*hi
    always_comb begin
        unique case (r_ph)
            2'd0:    acc_add = {64'd0, mul_p};
            2'd3:    acc_add = {mul_p, 64'd0};
            default: acc_add = {32'd0, mul_p, 32'd0};
        endcase
    end
    assign acc_new = r_acc + acc_add;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    unique case (t_action'(i_in.action))
                        ACT_LOAD_ROW: n_state = S_RESULT;
                        ACT_LOAD_SET: n_state = S_SCAN;
                        ACT_PROPOSE:  n_state = S_SCAN;
                        ACT_FINISH:   n_state = (r_cur_set == '0) ? S_DIV : S_RESULT;
                    endcase
                end
            end
            S_SCAN: begin
                if (r_idx == 5'(NODE_LIM - 1)) begin
                    if (r_act == ACT_LOAD_SET) n_state = S_RESULT;
                    else                       n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (r_dep)                          n_state = S_RESULT;
                else if (delta[12] || r_temp == '0) n_state = S_COOL;
                else                                n_state = S_DIV;
            end
            S_DIV: begin
                if (div_done) n_state = (r_act == ACT_FINISH) ? S_RESULT : S_EXP_CHK;
            end
            S_EXP_CHK: begin
                if (r_k == 4'(EXP_BITS)) n_state = S_COOL;
                else if (r_x[r_k])       n_state = S_MUL;
            end
            S_MUL:      n_state = S_ACC;
            S_ACC:      n_state = (r_ph == 2'd3) ? S_EXP_CHK : S_MUL;
            S_COOL:     n_state = S_COOL_ACC;
            S_COOL_ACC: n_state = S_RESULT;
            S_RESULT:   if (out_free) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // configuration and long-lived state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= NODE_COUNT_RST;
            r_init_temp  <= INIT_TEMP_RST;
            r_cool_rate  <= COOL_RATE_RST;
            r_cur_set    <= '0;
            r_cur_cost   <= '0;
            r_temp       <= INIT_TEMP_RST;
            for (int i = 0; i < MAX_NODES; i++) r_rows[i] <= '0;
        end else begin
            if (i_cfg.valid) begin
                if (i_cfg.index == REG_NODE_COUNT) r_node_count <= i_cfg.data[5:0];
                if (i_cfg.index == REG_INIT_TEMP)  r_init_temp  <= i_cfg.data;
                if (i_cfg.index == REG_COOL_RATE)  r_cool_rate  <= i_cfg.data[16:0];
            end
            if (r_state == S_IDLE && in_xfer && t_action'(i_in.action) == ACT_LOAD_ROW &&
                {1'b0, i_in.row_index} < 6'(MAX_NODES)) begin
                r_rows[i_in.row_index] <= i_in.vertex_bits;
            end
            if (r_state == S_SCAN && r_idx == 5'(NODE_LIM - 1) && r_act == ACT_LOAD_SET) begin
                r_cur_set  <= r_cand;
                r_cur_cost <= r_cand[r_idx] ?
                              (r_cost + 12'(signed'({1'b0, pc, 1'b0})) - 12'sd1) : r_cost;
                r_temp     <= r_init_temp;
            end
            if (r_state == S_DIV && div_done && r_act == ACT_FINISH) begin
                r_cur_set  <= {{(SET_W-1){1'b0}}, 1'b1} << div_rem[4:0];
                r_cur_cost <= -12'sd1;
            end
            if (r_state == S_COOL_ACC) begin
                r_temp <= mul_p[47:16];
                if (r_take) begin
                    r_cur_set  <= r_cand;
                    r_cur_cost <= r_cost;
                end
            end
        end
    end

    // per-item working registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_act    <= t_action'(i_in.action);
                r_cand   <= i_in.vertex_bits & node_mask;
                r_rnd    <= i_in.random_fraction;
                r_idx    <= '0;
                r_cost   <= '0;
                r_dep    <= 1'b0;
                r_take   <= 1'b0;
                r_status <= (t_action'(i_in.action) == ACT_FINISH) ? ST_FINISHED : ST_LOADED;
            end
            S_SCAN: begin
                r_idx <= r_idx + 5'd1;
                if (r_cand[r_idx]) begin
                    if ((row_now & r_cand) != '0) r_dep <= 1'b1;
                    if (r_idx != 5'(NODE_LIM - 1))
                        r_cost <= r_cost + 12'(signed'({1'b0, pc, 1'b0})) - 12'sd1;
                end
            end
            S_EVAL: begin
                r_status <= r_dep ? ST_DEPENDENT : ST_REJECTED;
                r_take   <= delta[12];
            end
            S_DIV: begin
                r_x   <= (div_quot > {{(DIV_W-EXP_BITS){1'b0}}, X_MAX}) ? X_MAX :
                         div_quot[EXP_BITS-1:0];
                r_k   <= '0;
                r_res <= Q62_ONE;
            end
            S_EXP_CHK: begin
                r_ph  <= '0;
                r_acc <= '0;
                if (r_k == 4'(EXP_BITS)) r_take <= {1'b0, r_rnd} < r_res[62:46];
                else if (!r_x[r_k])      r_k <= r_k + 4'd1;
            end
            S_ACC: begin
                r_acc <= acc_new;
                r_ph  <= r_ph + 2'd1;
                if (r_ph == 2'd3) begin
                    r_res <= acc_new[125:62];
                    r_k   <= r_k + 4'd1;
                end
            end
            S_COOL_ACC: begin
                r_status <= r_take ? ST_ACCEPTED : ST_REJECTED;
            end
            default: ;
        endcase
        // the last scan row folds its term in along with the accumulator
        if (r_state == S_SCAN && r_idx == 5'(NODE_LIM - 1) && r_cand[r_idx])
            r_cost <= r_cost + 12'(signed'({1'b0, pc, 1'b0})) - 12'sd1;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_RESULT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_RESULT && out_free) begin
            r_out_status <= r_status;
            r_out_set    <= r_cur_set;
            r_out_cost   <= r_cur_cost;
            r_out_temp   <= r_temp;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.status          = r_out_status;
    assign o_out.held_set        = r_out_set;
    assign o_out.set_cost        = r_out_cost;
    assign o_out.temperature_now = r_out_temp;

`ifndef SYNTHESIS
    a_row_load_quick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && t_action'(i_in.action) == ACT_LOAD_ROW) |=> (r_state == S_RESULT))
        else $error("row load did not go straight to result");
    a_exp_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ACC && r_ph == 2'd3) |=> (r_k == $past(r_k) + 4'd1))
        else $error("exponent bit counter did not advance");
    a_cool_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COOL_ACC) |=> (r_temp <= $past(r_temp)))
        else $error("cooling raised the temperature");
    a_dep_keeps_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EVAL && r_dep) |=> $stable(r_cur_set))
        else $error("dependent candidate changed the set");
`endif
endmodule
